>>> rtl/core/rc_pkg.sv
`default_nettype none

package rc_pkg;

  // Fixed field widths
  localparam int DATA_W = 16;              // Q1.15 signals and history
  localparam int WFRAC  = DATA_W - 2;      // Q2.14 weights: fraction bits
  localparam int ERR_W  = DATA_W + 1;      // reference - feedback, no saturation
  localparam int OPD_W  = DATA_W + 1;      // multiplier operand width
  localparam int PROD_W = 2 * OPD_W;       // full product width
  localparam int ACC_W  = 24;              // six truncated products summed
  localparam int LEN_CFG_W = 10;
  localparam int LIM_W  = 15;
  localparam int POS_W  = 16;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [OPD_W-1:0]  opd_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_HISTORY_LENGTH = 3'd0,
    REG_LEAD_STEPS     = 3'd1,
    REG_GAIN           = 3'd2,
    REG_WEIGHT_CENTER  = 3'd3,
    REG_WEIGHT_NEAR    = 3'd4,
    REG_WEIGHT_FAR     = 3'd5,
    REG_ACCUM_LIMIT    = 3'd6,
    REG_OUT_LIMIT      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [LEN_CFG_W-1:0] history_length;
    logic [LEN_CFG_W-1:0] lead_steps;
    data_t                gain;
    data_t                weight_center;
    data_t                weight_near;
    data_t                weight_far;
    logic [LIM_W-1:0]     accum_limit;
    logic [LIM_W-1:0]     out_limit;
  } cfg_t;

  // Shared multiplier operand selection
  typedef enum logic [2:0] {
    OP_INDEX,
    OP_GAIN,
    OP_CENTER,
    OP_NEAR,
    OP_FAR
  } mac_op_t;

  typedef struct packed {
    mac_op_t op;
    logic    acc_clr;
    logic    acc_add;
  } mac_ctl_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_CHECK,
    ST_MAC,
    ST_FINAL,
    ST_WRITE,
    ST_LEAD,
    ST_DONE
  } state_t;

  // Symmetric saturation to +-lim
  function automatic data_t clamp_sym(input acc_t v, input logic [LIM_W-1:0] lim);
    acc_t pos_lim;
    acc_t neg_lim;
    pos_lim = acc_t'({1'b0, lim});
    neg_lim = -pos_lim;
    if (v > pos_lim) begin
      return pos_lim[DATA_W-1:0];
    end else if (v < neg_lim) begin
      return neg_lim[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rc_in_if.sv
`default_nettype none

interface rc_in_if;
  import rc_pkg::*;

  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   sampling_position;
  data_t              reference;
  data_t              feedback;

  modport source (output valid, output sampling_position, output reference,
                  output feedback, input ready);
  modport sink   (input valid, input sampling_position, input reference,
                  input feedback, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rc_out_if.sv
`default_nettype none

interface rc_out_if;
  import rc_pkg::*;

  logic  valid;
  logic  ready;
  data_t drive;
  logic  updated;

  modport source (output valid, output drive, output updated, input ready);
  modport sink   (input valid, input drive, input updated, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rc_ram.sv
`default_nettype none

module rc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/rc_cfg.sv
`default_nettype none

module rc_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [rc_pkg::DATA_W-1:0] cfg_data,
  output rc_pkg::cfg_t                   cfg
);
  import rc_pkg::*;

  // Register file, reset to the documented defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.history_length <= LEN_CFG_W'(512);
      cfg.lead_steps     <= '0;
      cfg.gain           <= '0;
      cfg.weight_center  <= data_t'(16384);
      cfg.weight_near    <= '0;
      cfg.weight_far     <= '0;
      cfg.accum_limit    <= '1;
      cfg.out_limit      <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HISTORY_LENGTH: cfg.history_length <= cfg_data[LEN_CFG_W-1:0];
        REG_LEAD_STEPS:     cfg.lead_steps     <= cfg_data[LEN_CFG_W-1:0];
        REG_GAIN:           cfg.gain           <= cfg_data;
        REG_WEIGHT_CENTER:  cfg.weight_center  <= cfg_data;
        REG_WEIGHT_NEAR:    cfg.weight_near    <= cfg_data;
        REG_WEIGHT_FAR:     cfg.weight_far     <= cfg_data;
        REG_ACCUM_LIMIT:    cfg.accum_limit    <= cfg_data[LIM_W-1:0];
        REG_OUT_LIMIT:      cfg.out_limit      <= cfg_data[LIM_W-1:0];
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rc_mac.sv
`default_nettype none

module rc_mac #(
  parameter int LW = 10
) (
  input  wire logic                     clk,
  input  wire rc_pkg::mac_ctl_t         ctl,
  input  wire rc_pkg::cfg_t             cfg,
  input  wire logic [rc_pkg::POS_W-1:0] pos,
  input  wire rc_pkg::err_t             err,
  input  wire logic [LW-1:0]            len,
  input  wire rc_pkg::data_t            rdata,
  output rc_pkg::prod_t                 prod,
  output rc_pkg::acc_t                  acc
);
  import rc_pkg::*;

  opd_t opa;
  opd_t opb;
  acc_t prod_sh;

  // Operand select for the shared multiplier
  always_comb begin
    unique case (ctl.op)
      OP_INDEX: begin
        opa = opd_t'({1'b0, pos});
        opb = opd_t'(len);
      end
      OP_GAIN: begin
        opa = err;
        opb = opd_t'(cfg.gain);
      end
      OP_CENTER: begin
        opa = opd_t'(rdata);
        opb = opd_t'(cfg.weight_center);
      end
      OP_NEAR: begin
        opa = opd_t'(rdata);
        opb = opd_t'(cfg.weight_near);
      end
      OP_FAR: begin
        opa = opd_t'(rdata);
        opb = opd_t'(cfg.weight_far);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Drop the weight fraction bits: arithmetic shift floors toward -inf
  assign prod_sh = acc_t'(signed'(prod[PROD_W-1:WFRAC]));

  // Registered product, then accumulate
  always_ff @(posedge clk) begin
    prod <= opa * opb;
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_add) begin
      acc <= acc + prod_sh;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rc_seq.sv
`default_nettype none

module rc_seq #(
  parameter int MAX_HISTORY = 512,
  parameter int IW = $clog2(MAX_HISTORY),
  parameter int LW = $clog2(MAX_HISTORY + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire rc_pkg::cfg_t             cfg,
  rc_in_if.sink                         sample,
  rc_out_if.source                      result,
  output rc_pkg::mac_ctl_t              mac_ctl,
  output logic [rc_pkg::POS_W-1:0]      pos,
  output rc_pkg::err_t                  err,
  output logic [LW-1:0]                 len,
  input  wire rc_pkg::prod_t            prod,
  input  wire rc_pkg::acc_t             acc,
  output logic                          ram_we,
  output logic [IW-1:0]                 ram_waddr,
  output rc_pkg::data_t                 ram_wdata,
  output logic [IW-1:0]                 ram_raddr,
  input  wire rc_pkg::data_t            ram_rdata
);
  import rc_pkg::*;

  localparam int XW = LW + 2;

  state_t         state, state_next;
  logic [IW-1:0]  clr_cnt;
  logic [2:0]     step;
  logic [IW-1:0]  idx;
  logic [IW-1:0]  last_index;
  logic [IW-1:0]  lead_addr;
  data_t          held;
  data_t          wval;
  logic           upd;

  logic [LW-1:0]  lead;
  logic [15:0]    hl16;
  logic [15:0]    ld16;
  logic [IW-1:0]  new_idx;
  logic [IW-1:0]  tap_addr;
  logic signed [XW-1:0] tap_off;
  data_t          wval_c;
  data_t          held_c;
  logic           out_load;

  // Wrap an index in [-2, 2*len] onto [0, len-1]
  function automatic logic [IW-1:0] wrap_idx(input logic signed [XW-1:0] x,
                                             input logic [LW-1:0] l);
    logic signed [XW-1:0] t;
    logic signed [XW-1:0] ls;
    ls = signed'(XW'(l));
    t = x;
    if (t < 0) t = t + ls;
    if (t < 0) t = t + ls;
    if (t >= ls) t = t - ls;
    if (t >= ls) t = t - ls;
    return t[IW-1:0];
  endfunction

  // Effective length and lead
  assign hl16 = 16'(cfg.history_length);
  assign ld16 = 16'(cfg.lead_steps);
  always_comb begin
    if (hl16 == '0) begin
      len = LW'(1);
    end else if (hl16 > 16'(MAX_HISTORY)) begin
      len = LW'(MAX_HISTORY);
    end else begin
      len = hl16[LW-1:0];
    end
    lead = (ld16 > 16'(len)) ? len : ld16[LW-1:0];
  end

  // Index from the registered phase * length product
  assign new_idx = prod[16 +: IW];

  // Filter tap offsets: center, +1, -1, +2, -2
  always_comb begin
    case (step)
      3'd1:    tap_off = XW'(1);
      3'd2:    tap_off = -XW'(1);
      3'd3:    tap_off = XW'(2);
      3'd4:    tap_off = -XW'(2);
      default: tap_off = '0;
    endcase
  end
  assign tap_addr = wrap_idx(signed'(XW'(idx)) + tap_off, len);

  assign wval_c   = clamp_sym(acc, cfg.accum_limit);
  assign held_c   = clamp_sym(acc_t'(held), cfg.out_limit);
  assign out_load = (state == ST_DONE) && (!result.valid || result.ready);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    mac_ctl.op      = OP_GAIN;
    mac_ctl.acc_clr = 1'b0;
    mac_ctl.acc_add = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = wval_c;
    ram_raddr = tap_addr;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
        if (clr_cnt == IW'(MAX_HISTORY - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) state_next = ST_INDEX;
      end
      ST_INDEX: begin
        mac_ctl.op = OP_INDEX;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = (new_idx == last_index) ? ST_DONE : ST_MAC;
      end
      ST_MAC: begin
        mac_ctl.acc_clr = (step == 3'd0);
        mac_ctl.acc_add = (step != 3'd0);
        case (step)
          3'd0:         mac_ctl.op = OP_GAIN;
          3'd1:         mac_ctl.op = OP_CENTER;
          3'd2, 3'd3:   mac_ctl.op = OP_NEAR;
          default:      mac_ctl.op = OP_FAR;
        endcase
        if (step == 3'd5) state_next = ST_FINAL;
      end
      ST_FINAL: begin
        mac_ctl.acc_add = 1'b1;
        state_next      = ST_WRITE;
      end
      ST_WRITE: begin
        ram_we     = 1'b1;
        ram_raddr  = lead_addr;
        state_next = ST_LEAD;
      end
      ST_LEAD: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Control counters and history state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      step       <= '0;
      last_index <= '0;
      held       <= '0;
      upd        <= 1'b0;
    end else begin
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == ST_MAC) begin
        step <= step + 3'd1;
      end else begin
        step <= '0;
      end
      if (state == ST_CHECK) begin
        upd <= (new_idx != last_index);
        last_index <= new_idx;
      end
      if (state == ST_LEAD) held <= (lead_addr == idx) ? wval : ram_rdata;
      if (out_load) held <= held_c;
    end
  end

  // Transaction payload and working registers
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      pos <= sample.sampling_position;
      err <= err_t'(sample.reference) - err_t'(sample.feedback);
    end
    if (state == ST_CHECK) begin
      idx       <= new_idx;
      lead_addr <= wrap_idx(signed'(XW'(new_idx)) + signed'(XW'(lead)), len);
    end
    if (state == ST_WRITE) wval <= wval_c;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.drive   <= held_c;
      result.updated <= upd;
    end
  end

  // Checks
  data_t alim_s;
  data_t olim_s;
  assign alim_s = data_t'({1'b0, cfg.accum_limit});
  assign olim_s = data_t'({1'b0, cfg.out_limit});

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (idx < IW'(len) || LW > IW))
    else $error("history write index beyond effective length");

  a_write_saturated: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (wval_c <= alim_s && wval_c >= -alim_s))
    else $error("history write not saturated to accum_limit");

  a_drive_clamped: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (result.drive <= olim_s && result.drive >= -olim_s))
    else $error("drive not clamped to out_limit");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == ST_INDEX && !sample.ready))
    else $error("transaction accepted while busy");

  a_mac_steps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC && step == 3'd5) |=> (state == ST_FINAL))
    else $error("filter sequence overran");

endmodule

`default_nettype wire

>>> rtl/core/repetitive_controller_top.sv
`default_nettype none

// A transaction with an unchanged index passes ST_INDEX, ST_CHECK and ST_DONE; one
// that updates the history also passes ST_MAC (six passes of the one multiplier),
// ST_FINAL, ST_WRITE and ST_LEAD before ST_DONE, which waits for a free output. No
// new one is taken until ST_DONE is left, as all share the multiplier, accumulator
// and the one read port of the history RAM. Reset (synchronous, rst high): registers
// take defaults, then a clearing pass zeroes the history, during which none is taken.
module repetitive_controller_top #(
  parameter int MAX_HISTORY = 512
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [rc_pkg::DATA_W-1:0] cfg_data,
  rc_in_if.sink                          sample,
  rc_out_if.source                       result
);
  import rc_pkg::*;

  localparam int IW = $clog2(MAX_HISTORY);
  localparam int LW = $clog2(MAX_HISTORY + 1);

  cfg_t          cfg;
  mac_ctl_t      mac_ctl;
  logic [POS_W-1:0] pos;
  err_t          err;
  logic [LW-1:0] len;
  prod_t         prod;
  acc_t          acc;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  data_t         ram_wdata;
  logic [IW-1:0] ram_raddr;
  data_t         ram_rdata;

  rc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rc_seq #(
    .MAX_HISTORY (MAX_HISTORY),
    .IW          (IW),
    .LW          (LW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sample    (sample),
    .result    (result),
    .mac_ctl   (mac_ctl),
    .pos       (pos),
    .err       (err),
    .len       (len),
    .prod      (prod),
    .acc       (acc),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  rc_mac #(
    .LW (LW)
  ) u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .cfg   (cfg),
    .pos   (pos),
    .err   (err),
    .len   (len),
    .rdata (ram_rdata),
    .prod  (prod),
    .acc   (acc)
  );

  rc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_HISTORY),
    .AW    (IW)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
